// ===== hdl/generational_handle_pool_defines.svh =====
// Assertion macros shared by the generational handle pool RTL.
`ifndef GENERATIONAL_HANDLE_POOL_DEFINES_SVH
`define GENERATIONAL_HANDLE_POOL_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that a condition holds at every clock edge out of reset.
`define GHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("generational handle pool check failed");
// Check that a condition implies another in the same cycle.
`define GHP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("generational handle pool check failed");
// Check that a condition implies another in the following cycle.
`define GHP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("generational handle pool check failed");
`else
`define GHP_ASSERT(lbl, prop)
`define GHP_ASSERT_IMP(lbl, ante, cons)
`define GHP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/ghp_pkg.sv =====
// Types and constants of the generational handle pool.
package ghp_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 256;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned GEN_W = 24;
  localparam int unsigned TAG_W = 32;
  localparam int unsigned HND_W = GEN_W + IDX_W;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned REQ_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_LOOKUP = 3'd2,
    REQ_SET    = 3'd3,
    REQ_GET    = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    RD_IN   = 2'd0,
    RD_PICK = 2'd1,
    RD_CLR  = 2'd2,
    RD_SLOT = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [HND_W-1:0] handle_in;
    logic [TAG_W-1:0] tag_in;
  } in_t;

  typedef struct packed {
    logic             ok;
    logic [HND_W-1:0] handle_out;
    logic [IDX_W-1:0] slot_out;
    logic [TAG_W-1:0] tag_out;
    logic [CNT_W-1:0] live_count;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_req;
    logic    scan;
    logic    pick;
    logic    clr_wr;
    logic    exec;
    rd_sel_e rd_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

// ===== hdl/ghp_ctrl.sv =====
// Sequencing state machine of the generational handle pool.
module ghp_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ghp_pkg::REQ_W-1:0]  req_type_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  ghp_pkg::sts_t              sts_i,
  output ghp_pkg::cmd_t              cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ADD_SCAN = 3'd1;
  localparam logic [2:0] S_ADD_PICK = 3'd2;
  localparam logic [2:0] S_CLR_RD   = 3'd3;
  localparam logic [2:0] S_CLR_WR   = 3'd4;
  localparam logic [2:0] S_EXEC     = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.rd_sel   = ghp_pkg::RD_SLOT;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.rd_sel   = ghp_pkg::RD_IN;
        cmd_o.load_req = in_valid_i;
        if (in_valid_i) begin
          unique case (req_type_i)
            ghp_pkg::REQ_ADD:   state_d = S_ADD_SCAN;
            ghp_pkg::REQ_CLEAR: state_d = S_CLR_RD;
            default:            state_d = S_EXEC;
          endcase
        end
      end
      S_ADD_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = S_ADD_PICK;
      end
      S_ADD_PICK: begin
        cmd_o.pick   = 1'b1;
        cmd_o.rd_sel = ghp_pkg::RD_PICK;
        state_d      = S_EXEC;
      end
      S_CLR_RD: begin
        cmd_o.rd_sel = ghp_pkg::RD_CLR;
        state_d      = S_CLR_WR;
      end
      S_CLR_WR: begin
        cmd_o.clr_wr = 1'b1;
        state_d      = sts_i.clr_last ? S_EXEC : S_CLR_RD;
      end
      S_EXEC: begin
        // finish only once the result register is free
        cmd_o.exec = !out_valid_q || !out_stall_i;
        if (cmd_o.exec) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/ghp_dpath.sv =====
// Slot storage, free-slot search and request execution of the handle pool.
module ghp_dpath #(
  parameter int unsigned SLOT_COUNT = ghp_pkg::SLOT_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ghp_pkg::in_t  in_data_i,
  input  ghp_pkg::cmd_t cmd_i,
  output ghp_pkg::sts_t sts_o,
  output ghp_pkg::out_t res_o
);

  localparam int unsigned AW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned GW  = 16;
  localparam int unsigned GPW = $clog2(GW);
  localparam int unsigned GRP = (SLOT_COUNT + GW - 1) / GW;
  localparam int unsigned IW  = ghp_pkg::IDX_W;
  localparam int unsigned GNW = ghp_pkg::GEN_W;
  localparam int unsigned TW  = ghp_pkg::TAG_W;
  localparam int unsigned CW  = ghp_pkg::CNT_W;
  localparam logic [IW:0]   SLOT_LIM = (IW + 1)'(SLOT_COUNT);
  localparam logic [CW-1:0] CNT_LIM  = CW'(SLOT_COUNT);
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);

  function automatic logic [GNW-1:0] next_gen(input logic [GNW-1:0] g);
    logic [GNW-1:0] n;
    n = g + 1'b1;
    return (n == '0) ? GNW'(1) : n;
  endfunction

  // request and sequencing registers
  ghp_pkg::in_t   req_q;
  logic [AW-1:0]  slot_q;
  logic [AW-1:0]  clr_idx_q;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [SLOT_COUNT-1:0] alive_q;
  logic [SLOT_COUNT-1:0] gen_vld_q;

  // free-slot search
  logic [GRP-1:0]  grp_any_d, grp_any_q;
  logic [GPW-1:0]  grp_pos_d [GRP];
  logic [GPW-1:0]  grp_pos_q [GRP];
  logic [GW-1:0]   free_bits;
  logic [AW-1:0]   pick_idx;

  // memories
  logic [GNW-1:0] gen_mem [SLOT_COUNT];
  logic [TW-1:0]  tag_mem [SLOT_COUNT];
  logic [AW-1:0]  rd_addr;
  logic [GNW-1:0] gen_rd_q;
  logic           gv_rd_q;
  logic [TW-1:0]  tag_rd_q;

  logic           gen_we, tag_we;
  logic [AW-1:0]  gen_wa;
  logic [GNW-1:0] gen_wd;
  logic [TW-1:0]  tag_wd;

  logic [GNW-1:0] gen_eff;
  logic [IW-1:0]  h_idx;
  logic           in_range, h_ok, not_full;
  logic           alive_set, alive_clr;
  ghp_pkg::out_t  res_d, res_q;

  // first stage: lowest free position inside each group of slots
  always_comb begin
    free_bits = '0;
    for (int g = 0; g < int'(GRP); g++) begin
      free_bits = '0;
      for (int k = 0; k < int'(GW); k++) begin
        if (g * int'(GW) + k < int'(SLOT_COUNT)) begin
          free_bits[k] = !alive_q[g * int'(GW) + k];
        end
      end
      grp_any_d[g] = |free_bits;
      grp_pos_d[g] = '0;
      for (int k = int'(GW) - 1; k >= 0; k--) begin
        if (free_bits[k]) begin
          grp_pos_d[g] = GPW'(k);
        end
      end
    end
  end

  // second stage: lowest group that has a free slot
  always_comb begin
    pick_idx = '0;
    for (int g = int'(GRP) - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        pick_idx = AW'(g * int'(GW) + int'(grp_pos_q[g]));
      end
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      ghp_pkg::RD_IN:   rd_addr = in_data_i.handle_in[AW-1:0];
      ghp_pkg::RD_PICK: rd_addr = pick_idx;
      ghp_pkg::RD_CLR:  rd_addr = clr_idx_q;
      default:          rd_addr = slot_q;
    endcase
  end

  // an entry never written reads as its reset generation of one
  assign gen_eff  = gv_rd_q ? gen_rd_q : GNW'(1);
  assign h_idx    = req_q.handle_in[IW-1:0];
  assign in_range = ({1'b0, h_idx} < SLOT_LIM);
  assign h_ok     = (req_q.handle_in != '0) && in_range && alive_q[slot_q] &&
                    (req_q.handle_in[ghp_pkg::HND_W-1:IW] == gen_eff);
  assign not_full = (cnt_q < CNT_LIM);

  always_comb begin
    res_d     = '0;
    cnt_d     = cnt_q;
    gen_we    = 1'b0;
    gen_wa    = slot_q;
    gen_wd    = next_gen(gen_eff);
    tag_we    = 1'b0;
    tag_wd    = '0;
    alive_set = 1'b0;
    alive_clr = 1'b0;
    if (cmd_i.exec) begin
      case (req_q.req_type)
        ghp_pkg::REQ_ADD: begin
          if (not_full) begin
            alive_set        = 1'b1;
            tag_we           = 1'b1;
            cnt_d            = cnt_q + 1'b1;
            res_d.ok         = 1'b1;
            res_d.slot_out   = IW'(slot_q);
            res_d.handle_out = {gen_eff, IW'(slot_q)};
          end
        end
        ghp_pkg::REQ_REMOVE: begin
          if (h_ok) begin
            alive_clr      = 1'b1;
            gen_we         = 1'b1;
            cnt_d          = cnt_q - 1'b1;
            res_d.ok       = 1'b1;
            res_d.slot_out = h_idx;
          end
        end
        ghp_pkg::REQ_LOOKUP: begin
          res_d.ok       = h_ok;
          res_d.slot_out = h_ok ? h_idx : '0;
        end
        ghp_pkg::REQ_SET: begin
          tag_we         = h_ok;
          tag_wd         = req_q.tag_in;
          res_d.ok       = h_ok;
          res_d.slot_out = h_ok ? h_idx : '0;
        end
        ghp_pkg::REQ_GET: begin
          res_d.ok       = h_ok;
          res_d.slot_out = h_ok ? h_idx : '0;
          res_d.tag_out  = h_ok ? tag_rd_q : '0;
        end
        ghp_pkg::REQ_CLEAR: begin
          cnt_d    = '0;
          res_d.ok = 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd_i.clr_wr) begin
      gen_wa = clr_idx_q;
      gen_we = alive_q[clr_idx_q];
    end
    res_d.live_count = cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (tag_we) begin
      tag_mem[slot_q] <= tag_wd;
    end
    gen_rd_q <= gen_mem[rd_addr];
    gv_rd_q  <= gen_vld_q[rd_addr];
    tag_rd_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.scan) begin
      grp_any_q <= grp_any_d;
      grp_pos_q <= grp_pos_d;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      clr_idx_q <= '0;
      cnt_q     <= '0;
      alive_q   <= '0;
      gen_vld_q <= '0;
    end else begin
      if (cmd_i.load_req) begin
        slot_q    <= in_data_i.handle_in[AW-1:0];
        clr_idx_q <= '0;
      end else if (cmd_i.pick) begin
        slot_q <= pick_idx;
      end
      if (cmd_i.clr_wr) begin
        clr_idx_q          <= clr_idx_q + 1'b1;
        alive_q[clr_idx_q] <= 1'b0;
      end
      if (alive_set) begin
        alive_q[slot_q] <= 1'b1;
      end
      if (alive_clr) begin
        alive_q[slot_q] <= 1'b0;
      end
      if (gen_we) begin
        gen_vld_q[gen_wa] <= 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assign sts_o.clr_last = (clr_idx_q == LAST_IDX);
  assign res_o          = res_q;

endmodule

// ===== hdl/generational_handle_pool.sv =====
// Top level of the generational handle pool: slot map with checked handles.
//
//   channel | direction | handshake               | item
//   --------+-----------+-------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o | req_type, handle_in, tag_in
//   out     | output    | out_valid_o/out_stall_i | ok, handle_out, slot_out, tag_out,
//           |           |                         | live_count
//
// Remove, lookup, set tag, get tag and unknown requests read memory at the accept
// edge, then check and update in the execute state; add first runs the two-stage
// registered lowest-free search; clear walks all slots with a read state and a
// write state per slot. Reset clears no memory: generation valid bits make
// an unwritten slot read generation one. A stalled result holds in the output
// register; the next item is taken and waits in its final cycle for that register.
`include "generational_handle_pool_defines.svh"

module generational_handle_pool #(
  parameter int unsigned SLOT_COUNT = ghp_pkg::SLOT_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ghp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ghp_pkg::out_t out_data_o
);

  ghp_pkg::cmd_t cmd;
  ghp_pkg::sts_t sts;
  logic          res_has_handle;
  logic          handle_matches_slot;

  // sequence each request: search, clear walk, then execute into the result register
  ghp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (in_data_i.req_type),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // hold the slot state, check handles and build the result item
  ghp_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_o     (out_data_o)
  );

  assign res_has_handle      = out_valid_o && (out_data_o.handle_out != '0);
  assign handle_matches_slot = out_data_o.ok &&
      (out_data_o.handle_out[ghp_pkg::IDX_W-1:0] == out_data_o.slot_out);

  // a finished request always shows up as a result in the next cycle
  `GHP_ASSERT_NXT(a_exec_gives_result, cmd.exec, out_valid_o)
  // execution never overlaps the cycle in which new items are taken
  `GHP_ASSERT_IMP(a_no_exec_when_open, !in_stall_o, !cmd.exec)
  // the live count cannot exceed the pool size
  `GHP_ASSERT_IMP(a_count_bound, out_valid_o, out_data_o.live_count <= SLOT_COUNT)
  // a nonzero handle only comes from a successful add of the reported slot
  `GHP_ASSERT_IMP(a_handle_slot, res_has_handle, handle_matches_slot)

endmodule

// ===== verif/ghp_checker.sv =====
// Result predictor and checker for the generational handle pool channels.
module ghp_checker
  import ghp_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  in_t         in_data_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  out_t        out_data_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 1 << IDX_W;

  logic             alive_q [DEPTH];
  logic [GEN_W-1:0] gen_q   [DEPTH];
  logic [TAG_W-1:0] tag_q   [DEPTH];
  logic [CNT_W-1:0] live_q;
  out_t             pool_results_q [$];
  out_t             oldest;
  int unsigned      mismatches = 0;

  function automatic logic [GEN_W-1:0] bumped_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + 1'b1;
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

  function automatic logic handle_valid(input logic [HND_W-1:0] h,
                                        output logic [IDX_W-1:0] idx);
    idx = h[IDX_W-1:0];
    return (h != '0) && (int'(idx) < SLOT_COUNT) && alive_q[idx]
        && (h[HND_W-1:IDX_W] == gen_q[idx]);
  endfunction

  // Apply one request to the pool image and return the result it must produce.
  function automatic out_t predict_result(input in_t req);
    out_t             res;
    logic [IDX_W-1:0] idx;
    logic             hit;
    int               s;
    res = '0;
    hit = handle_valid(req.handle_in, idx);
    case (req.req_type)
      REQ_ADD: begin
        for (s = 0; s < SLOT_COUNT; s++) begin
          if (!alive_q[s]) break;
        end
        if (s < SLOT_COUNT) begin
          alive_q[s]     = 1'b1;
          tag_q[s]       = '0;
          live_q         = live_q + 1'b1;
          res.ok         = 1'b1;
          res.slot_out   = IDX_W'(s);
          res.handle_out = {gen_q[s], IDX_W'(s)};
        end
      end
      REQ_REMOVE: if (hit) begin
        alive_q[idx] = 1'b0;
        tag_q[idx]   = '0;
        gen_q[idx]   = bumped_gen(gen_q[idx]);
        if (live_q != '0) live_q = live_q - 1'b1;
        res.ok       = 1'b1;
        res.slot_out = idx;
      end
      REQ_LOOKUP: if (hit) begin
        res.ok       = 1'b1;
        res.slot_out = idx;
      end
      REQ_SET: if (hit) begin
        tag_q[idx]   = req.tag_in;
        res.ok       = 1'b1;
        res.slot_out = idx;
      end
      REQ_GET: if (hit) begin
        res.tag_out  = tag_q[idx];
        res.ok       = 1'b1;
        res.slot_out = idx;
      end
      REQ_CLEAR: begin
        for (s = 0; s < DEPTH; s++) begin
          if (alive_q[s]) gen_q[s] = bumped_gen(gen_q[s]);
          alive_q[s] = 1'b0;
          tag_q[s]   = '0;
        end
        live_q = '0;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.live_count = live_q;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp,
                             input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DEPTH; s++) begin
        alive_q[s] = 1'b0;
        gen_q[s]   = GEN_W'(1);
        tag_q[s]   = '0;
      end
      live_q = '0;
      pool_results_q.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pool_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_data_o);
          mismatches++;
        end else begin
          oldest = pool_results_q.pop_front();
          check_field("ok", 32'(oldest.ok), 32'(out_data_o.ok));
          check_field("handle_out", oldest.handle_out, out_data_o.handle_out);
          check_field("slot_out", 32'(oldest.slot_out), 32'(out_data_o.slot_out));
          check_field("tag_out", oldest.tag_out, out_data_o.tag_out);
          check_field("live_count", 32'(oldest.live_count), 32'(out_data_o.live_count));
        end
      end
      if (in_valid_i && !in_stall_o) pool_results_q.push_back(predict_result(in_data_i));
    end
    fail_count_o <= mismatches;
    pending_o    <= pool_results_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Stimulus, handshake pacing and verdict for the generational handle pool.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ghp_pkg::*;

  localparam int unsigned SLOTS      = SLOT_COUNT_DEF;
  // Longest legal silence is a clear walk behind a stalled result; allow far more.
  localparam int unsigned HANG_LIMIT = 20000;
  localparam int unsigned SEEN_MAX   = 64;
  // Request codes the block does not define; it must answer them with ok low.
  localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  int unsigned fail_count;
  int unsigned pending;

  // Pacing knobs, all in percent of cycles, and the request mix of a phase.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned add_pct       = 0;
  int unsigned clear_pct     = 0;

  // Handles handed out by the block; reused so that most requests reach real slots.
  logic [HND_W-1:0] seen_handles [$];
  int unsigned      quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  generational_handle_pool #(
    .SLOT_COUNT (SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  ghp_checker #(
    .SLOT_COUNT (SLOTS)
  ) pool_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Stall the result channel at random; a zero rate keeps it flowing freely.
  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Harvest fresh handles from accepted add results, and watch for a hang:
  // end the run once no item has moved on either channel for too long.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && out_data_o.ok && out_data_o.handle_out != '0) begin
      seen_handles.push_back(out_data_o.handle_out);
      if (seen_handles.size() > SEEN_MAX) void'(seen_handles.pop_front());
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Offer one item from a falling edge and hold it until the block takes it.
  // Idle cycles go in front of the item so valid is never dropped and raised
  // again in one step.
  task automatic push_req(input logic [REQ_W-1:0] kind, input logic [HND_W-1:0] handle,
                          input logic [TAG_W-1:0] tag);
    in_t req;
    req.req_type  = kind;
    req.handle_in = handle;
    req.tag_in    = tag;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Draw one request from the current mix. Mostly reuse a known handle,
  // sometimes with one bit flipped to make it stale or out of place, and
  // otherwise throw a fully random one.
  task automatic random_req();
    logic [REQ_W-1:0] kind;
    logic [HND_W-1:0] handle;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < add_pct) begin
      kind = REQ_ADD;
    end else if (pick < add_pct + clear_pct) begin
      kind = REQ_CLEAR;
    end else if (pick < add_pct + clear_pct + 2) begin
      kind = $urandom_range(1) ? REQ_RSVD_B : REQ_RSVD_A;
    end else begin
      case ($urandom_range(3))
        0:       kind = REQ_REMOVE;
        1:       kind = REQ_LOOKUP;
        2:       kind = REQ_SET;
        default: kind = REQ_GET;
      endcase
    end
    if (seen_handles.size() != 0 && $urandom_range(99) < 80) begin
      handle = seen_handles[$urandom_range(seen_handles.size() - 1)];
      if ($urandom_range(9) == 0) handle[$urandom_range(HND_W - 1)] ^= 1'b1;
    end else begin
      handle = $urandom;
    end
    push_req(kind, handle, $urandom);
  endtask

  task automatic run_phase(input int unsigned items, input int unsigned idle,
                           input int unsigned stall, input int unsigned adds,
                           input int unsigned clears);
    send_idle_pct = idle;
    stall_pct     = stall;
    add_pct       = adds;
    clear_pct     = clears;
    repeat (items) random_req();
  endtask

  initial begin
    // Hold reset low at start, then release it away from the rising edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero and all-ones handles on an empty pool.
    push_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    push_req(REQ_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill slots 0 and 1, each starting at generation one.
    push_req(REQ_ADD,    32'h0000_0000, 32'h0000_0000);
    push_req(REQ_ADD,    32'h0000_0000, 32'h0000_0000);
    push_req(REQ_SET,    32'h0000_0100, 32'hFFFF_FFFF);
    push_req(REQ_GET,    32'h0000_0100, 32'h0000_0000);
    push_req(REQ_SET,    32'h0000_0101, 32'hA5A5_5A5A);
    push_req(REQ_LOOKUP, 32'h0000_0101, 32'h0000_0000);
    // Wrong generation on a live slot.
    push_req(REQ_LOOKUP, 32'h0000_0201, 32'h0000_0000);
    // Remove, then reuse the now stale handle.
    push_req(REQ_REMOVE, 32'h0000_0100, 32'h0000_0000);
    push_req(REQ_REMOVE, 32'h0000_0100, 32'h0000_0000);
    push_req(REQ_GET,    32'h0000_0100, 32'h0000_0000);
    // Re-add into the freed slot: new generation, tag back to zero.
    push_req(REQ_ADD,    32'h0000_0000, 32'h0000_0000);
    push_req(REQ_GET,    32'h0000_0200, 32'h0000_0000);
    push_req(REQ_GET,    32'h0000_0101, 32'h0000_0000);
    // Undefined request codes, the first with every field bit set.
    push_req(REQ_RSVD_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(REQ_RSVD_B, 32'h0000_0101, 32'hFFFF_FFFF);
    // Clear bumps every live slot; old handles die.
    push_req(REQ_CLEAR,  32'h0000_0000, 32'h0000_0000);
    push_req(REQ_LOOKUP, 32'h0000_0101, 32'h0000_0000);
    push_req(REQ_ADD,    32'h0000_0000, 32'h0000_0000);
    push_req(REQ_ADD,    32'h0000_0000, 32'h0000_0000);
    push_req(REQ_LOOKUP, 32'h0000_0201, 32'h0000_0000);
    push_req(REQ_CLEAR,  32'h0000_0000, 32'h0000_0000);

    // Random phases: free flow, slow sender while adds drive the pool to full
    // and beyond, heavy result stalls, then light idling on both sides.
    run_phase(300, 0,  0,  40, 2);
    run_phase(300, 66, 0,  92, 0);
    run_phase(300, 0,  66, 35, 2);
    run_phase(250, 15, 15, 45, 3);
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then leave room for a full clear walk
    // so a stray late result still gets caught.
    while (pending != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 8) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
